// ===== sv/least_squares_line_fit_top_assert.svh =====
// assertion macros for the line fit block
// they sample on clk_i and are off while rst_ni is low
`ifndef LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH

// whenever ante holds, cons holds in the same cycle
`define LSLF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line fit check failed");

// expr never holds
`define LSLF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("line fit check failed");

`endif

// ===== sv/lslf_pkg.sv =====
package lslf_pkg;

  // defaults for the top level parameters
  localparam int unsigned NumPointsDef = 6;
  localparam int unsigned FifoDepthDef = 2;

  // field widths
  localparam int unsigned InW   = 24;
  localparam int unsigned YW    = InW + 1;
  localparam int unsigned OutW  = 32;
  localparam int unsigned StatW = 2;

  // running sums, sized for up to 64 points
  localparam int unsigned SumXW  = 31;
  localparam int unsigned SumYW  = 32;
  localparam int unsigned SumXyW = 55;
  localparam int unsigned SumXxW = 55;

  // fit terms: denominator, slope numerator, intercept numerator
  localparam int unsigned DenW = 63;
  localparam int unsigned NmW  = 64;
  localparam int unsigned NbW  = 88;
  localparam int unsigned AccW = 88;

  // shared multiplier and limb split of the wide sums
  localparam int unsigned OpW   = 33;
  localparam int unsigned ProdW = 2 * OpW;
  localparam int unsigned LimbW = 28;

  // divider widths
  localparam int unsigned SlopeShift = 16;
  localparam int unsigned IcptShift  = 8;
  localparam int unsigned MagW = NbW + IcptShift;
  localparam int unsigned DmW  = DenW;
  localparam int unsigned D2W  = DmW + 1;
  localparam int unsigned N2W  = MagW + 2;
  localparam int unsigned QW   = OutW;

  localparam logic [OutW-1:0] SatPos = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] SatNeg = {1'b1, {(OutW-1){1'b0}}};

  // one queued point
  typedef struct packed {
    logic signed [InW-1:0] x;
    logic signed [YW-1:0]  y;
    logic                  last;
  } point_t;

  // terms handed from the accumulator to the divider
  typedef struct packed {
    logic signed [DenW-1:0] den;
    logic signed [NmW-1:0]  nm;
    logic signed [NbW-1:0]  nb;
  } fit_job_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_XY,
    ACC_XX,
    ACC_DEN,
    ACC_NM,
    ACC_NB
  } acc_sel_e;

  typedef enum logic [2:0] {
    MAC_POINT,
    MAC_SQUARE,
    MAC_DRAIN,
    MAC_FIN,
    MAC_FLUSH,
    MAC_HAND
  } mac_state_e;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MAG,
    DIV_ADD,
    DIV_CHECK,
    DIV_ITER,
    DIV_ROUND,
    DIV_OUT
  } div_state_e;

  typedef enum logic [StatW-1:0] {
    FIT_OK,
    FIT_ZERO_DEN,
    FIT_SAT
  } fit_status_e;

endpackage

// ===== sv/lslf_front.sv =====
module lslf_front import lslf_pkg::*; #(
  parameter int unsigned NUM_POINTS = NumPointsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic signed [InW-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [InW-1:0] final_temperature_i,
  input  logic signed [InW-1:0] added_mass_i,
  input  logic                  full_i,
  output logic                  push_o,
  output point_t                push_data_o
);

  localparam int unsigned CntW = $clog2(NUM_POINTS);

  logic signed [InW-1:0] init_temp_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  last;

  // initial temperature register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_temp_q <= '0;
    end else if (cfg_we_i) begin
      init_temp_q <= cfg_data_i;
    end
  end

  // take a beat whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // position of the point within its set
  assign last = (cnt_q == CntW'(NUM_POINTS - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // y is the temperature rise, tagged with end of set
  assign push_data_o.x    = added_mass_i;
  assign push_data_o.y    = $signed({final_temperature_i[InW-1], final_temperature_i})
                          - $signed({init_temp_q[InW-1], init_temp_q});
  assign push_data_o.last = last;

endmodule

// ===== sv/lslf_fifo.sv =====
module lslf_fifo import lslf_pkg::*; #(
  parameter int unsigned WIDTH = $bits(point_t),
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lslf_mac.sv =====
module lslf_mac import lslf_pkg::*; #(
  parameter int unsigned NUM_POINTS = NumPointsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pt_valid_i,
  input  point_t   pt_i,
  output logic     pt_pop_o,
  output logic     job_valid_o,
  output fit_job_t job_o,
  input  logic     job_ready_i
);

  typedef enum logic [3:0] {
    FS_DEN_LO,
    FS_DEN_HI,
    FS_DEN_SQ,
    FS_NM_LO,
    FS_NM_HI,
    FS_NM_XY,
    FS_NB_LO,
    FS_NB_HI,
    FS_NB_XLO,
    FS_NB_XHI
  } fin_step_e;

  mac_state_e state_q, state_d;
  fin_step_e  step_q, step_d;

  logic signed [InW-1:0]    x_q;
  logic                     last_q;
  logic signed [SumXW-1:0]  sum_x_q;
  logic signed [SumYW-1:0]  sum_y_q;
  logic signed [SumXyW-1:0] sum_xy_q;
  logic signed [SumXxW-1:0] sum_xx_q;
  logic signed [DenW-1:0]   den_q;
  logic signed [NmW-1:0]    nm_q;
  logic signed [NbW-1:0]    nb_q;

  // multiplier stage
  logic signed [OpW-1:0]   op_a, op_b;
  acc_sel_e                op_dst, dst_q;
  logic                    op_shl, op_sub, shl_q, sub_q;
  logic signed [ProdW-1:0] prod_d, prod_q;

  logic clr_sums, clr_fit;

  // operand forms of the sums
  logic signed [OpW-1:0] n_op, sx_op, sy_op, xq_op, hx_op, hy_op;
  logic signed [OpW-1:0] xx_lo, xx_hi, xy_lo, xy_hi;

  // accumulate stage
  logic [AccW-1:0] acc_cur, p_ext, term, addend, acc_sum;

  assign n_op  = OpW'(NUM_POINTS);
  assign sx_op = $signed({{(OpW-SumXW){sum_x_q[SumXW-1]}}, sum_x_q});
  assign sy_op = $signed({{(OpW-SumYW){sum_y_q[SumYW-1]}}, sum_y_q});
  assign xq_op = $signed({{(OpW-InW){x_q[InW-1]}}, x_q});
  assign hx_op = $signed({{(OpW-InW){pt_i.x[InW-1]}}, pt_i.x});
  assign hy_op = $signed({{(OpW-YW){pt_i.y[YW-1]}}, pt_i.y});

  // low limb unsigned, high limb signed
  assign xx_lo = $signed({{(OpW-LimbW){1'b0}}, sum_xx_q[LimbW-1:0]});
  assign xx_hi = $signed({{(OpW-SumXxW+LimbW){sum_xx_q[SumXxW-1]}},
                          sum_xx_q[SumXxW-1:LimbW]});
  assign xy_lo = $signed({{(OpW-LimbW){1'b0}}, sum_xy_q[LimbW-1:0]});
  assign xy_hi = $signed({{(OpW-SumXyW+LimbW){sum_xy_q[SumXyW-1]}},
                          sum_xy_q[SumXyW-1:LimbW]});

  // sequencer: two products per point, ten more products to finish each set
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pt_pop_o    = 1'b0;
    job_valid_o = 1'b0;
    op_a        = '0;
    op_b        = '0;
    op_dst      = ACC_NONE;
    op_shl      = 1'b0;
    op_sub      = 1'b0;
    clr_sums    = 1'b0;
    clr_fit     = 1'b0;
    unique case (state_q)
      MAC_POINT: begin
        if (pt_valid_i) begin
          pt_pop_o = 1'b1;
          op_a     = hx_op;
          op_b     = hy_op;
          op_dst   = ACC_XY;
          state_d  = MAC_SQUARE;
        end
      end
      MAC_SQUARE: begin
        op_a    = xq_op;
        op_b    = xq_op;
        op_dst  = ACC_XX;
        state_d = last_q ? MAC_DRAIN : MAC_POINT;
      end
      MAC_DRAIN: begin
        clr_fit = 1'b1;
        step_d  = FS_DEN_LO;
        state_d = MAC_FIN;
      end
      MAC_FIN: begin
        unique case (step_q)
          FS_DEN_LO: begin
            op_a = n_op;  op_b = xx_lo; op_dst = ACC_DEN;
          end
          FS_DEN_HI: begin
            op_a = n_op;  op_b = xx_hi; op_dst = ACC_DEN; op_shl = 1'b1;
          end
          FS_DEN_SQ: begin
            op_a = sx_op; op_b = sx_op; op_dst = ACC_DEN; op_sub = 1'b1;
          end
          FS_NM_LO: begin
            op_a = n_op;  op_b = xy_lo; op_dst = ACC_NM;
          end
          FS_NM_HI: begin
            op_a = n_op;  op_b = xy_hi; op_dst = ACC_NM; op_shl = 1'b1;
          end
          FS_NM_XY: begin
            op_a = sx_op; op_b = sy_op; op_dst = ACC_NM; op_sub = 1'b1;
          end
          FS_NB_LO: begin
            op_a = sy_op; op_b = xx_lo; op_dst = ACC_NB;
          end
          FS_NB_HI: begin
            op_a = sy_op; op_b = xx_hi; op_dst = ACC_NB; op_shl = 1'b1;
          end
          FS_NB_XLO: begin
            op_a = sx_op; op_b = xy_lo; op_dst = ACC_NB; op_sub = 1'b1;
          end
          FS_NB_XHI: begin
            op_a = sx_op; op_b = xy_hi; op_dst = ACC_NB;
            op_shl = 1'b1; op_sub = 1'b1;
          end
          default: begin
            op_dst = ACC_NONE;
          end
        endcase
        if (step_q == FS_NB_XHI) begin
          clr_sums = 1'b1;
          state_d  = MAC_FLUSH;
        end else begin
          step_d = fin_step_e'(step_q + 4'd1);
        end
      end
      MAC_FLUSH: begin
        state_d = MAC_HAND;
      end
      MAC_HAND: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = MAC_POINT;
        end
      end
      default: begin
        state_d = MAC_POINT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MAC_POINT;
      step_q  <= FS_DEN_LO;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // point held for its square
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (pt_pop_o) begin
      last_q <= pt_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_pop_o) begin
      x_q <= pt_i.x;
    end
  end

  // shared multiplier, product registered
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    shl_q  <= op_shl;
    sub_q  <= op_sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= ACC_NONE;
    end else begin
      dst_q <= op_dst;
    end
  end

  // pick the accumulator the product lands in
  always_comb begin
    unique case (dst_q)
      ACC_XY:  acc_cur = {{(AccW-SumXyW){sum_xy_q[SumXyW-1]}}, sum_xy_q};
      ACC_XX:  acc_cur = {{(AccW-SumXxW){sum_xx_q[SumXxW-1]}}, sum_xx_q};
      ACC_DEN: acc_cur = {{(AccW-DenW){den_q[DenW-1]}}, den_q};
      ACC_NM:  acc_cur = {{(AccW-NmW){nm_q[NmW-1]}}, nm_q};
      ACC_NB:  acc_cur = nb_q;
      default: acc_cur = '0;
    endcase
  end

  // add or subtract the product, high limbs shifted up
  assign p_ext   = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign term    = shl_q ? (p_ext << LimbW) : p_ext;
  assign addend  = sub_q ? ~term : term;
  assign acc_sum = acc_cur + addend + AccW'(sub_q);

  // running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
    end else if (clr_sums) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
    end else begin
      if (pt_pop_o) begin
        sum_x_q <= sum_x_q + $signed({{(SumXW-InW){pt_i.x[InW-1]}}, pt_i.x});
        sum_y_q <= sum_y_q + $signed({{(SumYW-YW){pt_i.y[YW-1]}}, pt_i.y});
      end
      if (dst_q == ACC_XY) begin
        sum_xy_q <= acc_sum[SumXyW-1:0];
      end
      if (dst_q == ACC_XX) begin
        sum_xx_q <= acc_sum[SumXxW-1:0];
      end
    end
  end

  // fit terms, cleared before each set is finished
  always_ff @(posedge clk_i) begin
    if (clr_fit) begin
      den_q <= '0;
      nm_q  <= '0;
      nb_q  <= '0;
    end else begin
      if (dst_q == ACC_DEN) begin
        den_q <= acc_sum[DenW-1:0];
      end
      if (dst_q == ACC_NM) begin
        nm_q <= acc_sum[NmW-1:0];
      end
      if (dst_q == ACC_NB) begin
        nb_q <= acc_sum[NbW-1:0];
      end
    end
  end

  assign job_o.den = den_q;
  assign job_o.nm  = nm_q;
  assign job_o.nb  = nb_q;

endmodule

// ===== sv/lslf_div.sv =====
module lslf_div import lslf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  fit_job_t         job_i,
  output logic             job_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OutW-1:0]  slope_o,
  output logic [OutW-1:0]  intercept_o,
  output logic [StatW-1:0] fit_status_o
);

  localparam int unsigned CntW = $clog2(QW);
  localparam int unsigned HiW  = N2W - QW;

  div_state_e  state_q, state_d;
  fit_job_t    job_q, job_d;
  logic        icpt_phase_q, icpt_phase_d;
  logic        sat_q, sat_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DmW-1:0]  dm_q, dm_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [N2W-1:0]  n2_q, n2_d;
  logic [D2W-1:0]  rem_q, rem_d;
  logic [QW-1:0]   lo_q, lo_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [OutW-1:0] slope_q, slope_d, icpt_q, icpt_d;
  fit_status_e     status_q, status_d;

  logic [NbW-1:0]  nb_mag;
  logic [NmW-1:0]  nm_mag;
  logic [D2W-1:0]  d2;
  logic [HiW-1:0]  n2_hi;
  logic [D2W:0]    rem2, diff;
  logic            ge;
  logic [OutW-1:0] limit, qsat, res;
  logic            over;

  // magnitudes of the terms
  assign nb_mag = job_q.nb[NbW-1] ? (~job_q.nb + NbW'(1)) : job_q.nb;
  assign nm_mag = job_q.nm[NmW-1] ? (~job_q.nm + NmW'(1)) : job_q.nm;
  assign d2     = {dm_q, 1'b0};
  assign n2_hi  = n2_q[N2W-1:QW];

  // one restoring step
  assign rem2 = {rem_q, lo_q[QW-1]};
  assign ge   = (rem2 >= {1'b0, d2});
  assign diff = rem2 - {1'b0, d2};

  // clamp and sign
  assign limit = neg_q ? SatNeg : SatPos;
  assign over  = ovf_q || (quo_q > limit);
  assign qsat  = over ? limit : quo_q;
  assign res   = neg_q ? (~qsat + OutW'(1)) : qsat;

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    icpt_phase_d = icpt_phase_q;
    sat_d        = sat_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    dm_d         = dm_q;
    mag_d        = mag_q;
    n2_d         = n2_q;
    rem_d        = rem_q;
    lo_d         = lo_q;
    quo_d        = quo_q;
    slope_d      = slope_q;
    icpt_d       = icpt_q;
    status_d     = status_q;
    job_ready_o  = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          job_d        = job_i;
          icpt_phase_d = 1'b0;
          sat_d        = 1'b0;
          if (job_i.den == '0) begin
            slope_d  = '0;
            icpt_d   = '0;
            status_d = FIT_ZERO_DEN;
            state_d  = DIV_OUT;
          end else begin
            state_d = DIV_MAG;
          end
        end
      end
      // scaled numerator magnitude and sign of the quotient
      DIV_MAG: begin
        dm_d = job_q.den[DenW-1] ? DmW'(~job_q.den + DenW'(1)) : DmW'(job_q.den);
        if (icpt_phase_q) begin
          mag_d = {{(MagW-NbW){1'b0}}, nb_mag} << IcptShift;
          neg_d = job_q.nb[NbW-1] ^ job_q.den[DenW-1];
        end else begin
          mag_d = {{(MagW-NmW){1'b0}}, nm_mag} << SlopeShift;
          neg_d = job_q.nm[NmW-1] ^ job_q.den[DenW-1];
        end
        state_d = DIV_ADD;
      end
      // half a divisor added for round to nearest
      DIV_ADD: begin
        n2_d    = {1'b0, mag_q, 1'b0} + {{(N2W-DmW){1'b0}}, dm_q};
        state_d = DIV_CHECK;
      end
      // quotient too big for 32 bits when the top part reaches the divisor
      DIV_CHECK: begin
        ovf_d = (n2_hi >= {{(HiW-D2W){1'b0}}, d2});
        rem_d = n2_hi[D2W-1:0];
        lo_d  = n2_q[QW-1:0];
        quo_d = '0;
        cnt_d = '0;
        state_d = ovf_d ? DIV_ROUND : DIV_ITER;
      end
      DIV_ITER: begin
        rem_d = ge ? diff[D2W-1:0] : rem2[D2W-1:0];
        lo_d  = lo_q << 1;
        quo_d = {quo_q[QW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          state_d = DIV_ROUND;
        end
      end
      DIV_ROUND: begin
        sat_d = sat_q || over;
        if (icpt_phase_q) begin
          icpt_d   = res;
          status_d = (sat_q || over) ? FIT_SAT : FIT_OK;
          state_d  = DIV_OUT;
        end else begin
          slope_d      = res;
          icpt_phase_d = 1'b1;
          state_d      = DIV_MAG;
        end
      end
      DIV_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= DIV_IDLE;
      icpt_phase_q <= 1'b0;
      sat_q        <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      icpt_phase_q <= icpt_phase_d;
      sat_q        <= sat_d;
      cnt_q        <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    neg_q    <= neg_d;
    ovf_q    <= ovf_d;
    dm_q     <= dm_d;
    mag_q    <= mag_d;
    n2_q     <= n2_d;
    rem_q    <= rem_d;
    lo_q     <= lo_d;
    quo_q    <= quo_d;
    slope_q  <= slope_d;
    icpt_q   <= icpt_d;
    status_q <= status_d;
  end

  assign slope_o      = slope_q;
  assign intercept_o  = icpt_q;
  assign fit_status_o = status_q;

endmodule

// ===== sv/least_squares_line_fit_top.sv =====
// channel   | signals                                      | beat
// ----------+----------------------------------------------+---------------------------
// config    | cfg_we_i, cfg_data_i                         | write when cfg_we_i is high
// point in  | in_valid_i/in_ready_o, final_temperature_i,  | valid and ready both high
//           | added_mass_i                                 |
// fit out   | out_valid_o/out_ready_i, slope_o,            | valid and ready both high
//           | intercept_o, fit_status_o                    |
//
// a point takes two products of the one shared 33x33 multiplier; the last point of a set
// adds ten limb products before the terms go to the divider
// the radix-2 divider forms the slope and then the intercept quotient of each set,
// rounds and clamps them, and takes no new set until the result beat is taken
// the point queue lets the front accept beats while the divider works
// reset clears all control state and the initial temperature; there is no clearing pass
`include "least_squares_line_fit_top_assert.svh"

module least_squares_line_fit_top import lslf_pkg::*; #(
  parameter int unsigned NUM_POINTS = NumPointsDef,
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic signed [InW-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [InW-1:0] final_temperature_i,
  input  logic signed [InW-1:0] added_mass_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OutW-1:0]       slope_o,
  output logic [OutW-1:0]       intercept_o,
  output logic [StatW-1:0]      fit_status_o
);

  logic     push, full, pop, empty;
  point_t   push_data;
  logic [$bits(point_t)-1:0] head_bits;
  point_t   head;
  logic     job_valid, job_ready;
  fit_job_t job;

  // front: config, y and end of set tagging
  lslf_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .final_temperature_i (final_temperature_i),
    .added_mass_i        (added_mass_i),
    .full_i              (full),
    .push_o              (push),
    .push_data_o         (push_data)
  );

  // point queue
  lslf_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_bits),
    .empty_o (empty)
  );

  assign head = point_t'(head_bits);

  // back: sums and fit terms
  lslf_mac #(
    .NUM_POINTS (NUM_POINTS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (!empty),
    .pt_i        (head),
    .pt_pop_o    (pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // back: rounded divisions and result register
  lslf_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_ready_o  (job_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slope_o      (slope_o),
    .intercept_o  (intercept_o),
    .fit_status_o (fit_status_o)
  );

  // checks
  `LSLF_ASSERT_IMPLY(zero_den_zero_fit_a, out_valid_o && (fit_status_o == FIT_ZERO_DEN),
    (slope_o == '0) && (intercept_o == '0))
  `LSLF_ASSERT_IMPLY(sat_at_limit_a, out_valid_o && (fit_status_o == FIT_SAT),
    (slope_o == SatPos) || (slope_o == SatNeg) || (intercept_o == SatPos) || (intercept_o == SatNeg))
  `LSLF_ASSERT_NEVER(no_pop_in_handoff_a, pop && job_valid)

endmodule

// ===== tb/sv/lslf_fit_checker.sv =====
`timescale 1ns / 1ps

module lslf_fit_checker import lslf_pkg::*; #(
  parameter int unsigned NUM_POINTS = NumPointsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic signed [InW-1:0] cfg_data_i,
  input  logic                  pt_valid_i,
  input  logic                  pt_ready_i,
  input  logic signed [InW-1:0] final_temperature_i,
  input  logic signed [InW-1:0] added_mass_i,
  input  logic                  fit_valid_i,
  input  logic                  fit_ready_i,
  input  logic [OutW-1:0]       slope_i,
  input  logic [OutW-1:0]       intercept_i,
  input  logic [StatW-1:0]      fit_status_i,
  output int                    fail_count_o,
  output int                    fits_owed_o
);

  // wide enough for the shifted intercept numerator with headroom
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [OutW-1:0] slope;
    logic [OutW-1:0] intercept;
    fit_status_e     status;
  } line_fit_t;

  line_fit_t               owed_fits[$];
  logic signed [InW-1:0]   start_temp = '0;
  int unsigned             points_seen = 0;
  logic signed [SumXW-1:0]  sum_x = '0;
  logic signed [SumYW-1:0]  sum_y = '0;
  logic signed [SumXyW-1:0] sum_xy = '0;
  logic signed [SumXxW-1:0] sum_xx = '0;

  // num/den rounded to nearest, ties away from zero, clamped to 32 bits
  function automatic logic [OutW-1:0] round_clamp_quotient(input wide_t num, input wide_t den,
                                                           output logic clipped);
    logic            neg;
    wide_t           mag_n;
    wide_t           mag_d;
    wide_t           quo;
    wide_t           lim;
    logic [OutW-1:0] res;
    neg   = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo   = (2 * mag_n + mag_d) / (2 * mag_d);
    lim   = neg ? (wide_t'(1) <<< (OutW - 1)) : (wide_t'(1) <<< (OutW - 1)) - 1;
    clipped = quo > lim;
    if (clipped) begin
      quo = lim;
    end
    res = neg ? -quo : quo;
    return res;
  endfunction

  // fold one point into the sums, close the fit on the last point of a set
  task automatic accumulate_point(input logic signed [InW-1:0] temp,
                                  input logic signed [InW-1:0] mass);
    logic signed [YW-1:0] rise;
    wide_t                n;
    wide_t                sx;
    wide_t                sy;
    wide_t                sxy;
    wide_t                sxx;
    wide_t                den;
    wide_t                nm;
    wide_t                nb;
    logic                 clip_m;
    logic                 clip_b;
    line_fit_t            fit;
    rise   = temp - start_temp;
    sum_x  = sum_x + mass;
    sum_y  = sum_y + rise;
    sum_xy = sum_xy + mass * rise;
    sum_xx = sum_xx + mass * mass;
    points_seen++;
    if (points_seen >= NUM_POINTS) begin
      n   = NUM_POINTS;
      sx  = sum_x;
      sy  = sum_y;
      sxy = sum_xy;
      sxx = sum_xx;
      den = n * sxx - sx * sx;
      if (den == 0) begin
        fit.slope     = '0;
        fit.intercept = '0;
        fit.status    = FIT_ZERO_DEN;
      end else begin
        nm = n * sxy - sx * sy;
        nb = sy * sxx - sxy * sx;
        fit.slope     = round_clamp_quotient(nm <<< SlopeShift, den, clip_m);
        fit.intercept = round_clamp_quotient(nb <<< IcptShift, den, clip_b);
        fit.status    = (clip_m || clip_b) ? FIT_SAT : FIT_OK;
      end
      owed_fits.push_back(fit);
      points_seen = 0;
      sum_x  = '0;
      sum_y  = '0;
      sum_xy = '0;
      sum_xx = '0;
    end
  endtask

  // compare one fit beat against the oldest owed fit
  task automatic check_fit_beat();
    line_fit_t want;
    if (owed_fits.size() == 0) begin
      $error("fit beat with none owed: slope %h intercept %h status %0d",
             slope_i, intercept_i, fit_status_i);
      fail_count_o++;
    end else begin
      want = owed_fits.pop_front();
      if (slope_i !== want.slope) begin
        $error("slope mismatch: expected %h, actual %h", want.slope, slope_i);
        fail_count_o++;
      end
      if (intercept_i !== want.intercept) begin
        $error("intercept mismatch: expected %h, actual %h", want.intercept, intercept_i);
        fail_count_o++;
      end
      if (fit_status_i !== want.status) begin
        $error("fit_status mismatch: expected %0d, actual %0d", want.status, fit_status_i);
        fail_count_o++;
      end
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_temp  = '0;
      points_seen = 0;
      sum_x       = '0;
      sum_y       = '0;
      sum_xy      = '0;
      sum_xx      = '0;
      owed_fits.delete();
      fits_owed_o = 0;
    end else begin
      if (pt_valid_i && pt_ready_i) begin
        accumulate_point(final_temperature_i, added_mass_i);
      end
      if (fit_valid_i && fit_ready_i) begin
        check_fit_beat();
      end
      // register takes effect for points after this edge
      if (cfg_we_i) begin
        start_temp = cfg_data_i;
      end
      fits_owed_o = owed_fits.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lslf_pkg::*;

  localparam int unsigned NumPoints = NumPointsDef;
  localparam int HalfPeriodNs = 5;
  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 160;
  localparam int RandomPoints = 600;
  localparam int PhasePoints  = 200;
  localparam int TempEvery    = 50;
  localparam int TimeoutNs    = 5_000_000;

  localparam logic [InW-1:0] MaxIn = {1'b0, {(InW-1){1'b1}}};
  localparam logic [InW-1:0] MinIn = {1'b1, {(InW-1){1'b0}}};

  typedef enum int {
    SHAPE_FULL,
    SHAPE_NARROW,
    SHAPE_LINE,
    SHAPE_FLAT_X
  } set_shape_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic signed [InW-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic signed [InW-1:0] final_temperature_i;
  logic signed [InW-1:0] added_mass_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OutW-1:0]       slope_o;
  logic [OutW-1:0]       intercept_o;
  logic [StatW-1:0]      fit_status_o;

  int          src_idle_pct = 29;
  int          snk_idle_pct = 73;
  int          fail_count;
  int          fits_owed;
  int unsigned slot = 0;
  set_shape_e  shape = SHAPE_FULL;
  int          line_gain = 0;
  logic [InW-1:0] flat_mass = '0;

  always #(HalfPeriodNs) clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  least_squares_line_fit_top #(
    .NUM_POINTS(NumPoints)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .final_temperature_i(final_temperature_i),
    .added_mass_i       (added_mass_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .slope_o            (slope_o),
    .intercept_o        (intercept_o),
    .fit_status_o       (fit_status_o)
  );

  lslf_fit_checker #(
    .NUM_POINTS(NumPoints)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .pt_valid_i         (in_valid_i),
    .pt_ready_i         (in_ready_o),
    .final_temperature_i(final_temperature_i),
    .added_mass_i       (added_mass_i),
    .fit_valid_i        (out_valid_o),
    .fit_ready_i        (out_ready_i),
    .slope_i            (slope_o),
    .intercept_i        (intercept_o),
    .fit_status_i       (fit_status_o),
    .fail_count_o       (fail_count),
    .fits_owed_o        (fits_owed)
  );

  // hard stop in case the block hangs
  initial begin
    #(TimeoutNs);
    $display("** least_squares_line_fit_top: FAILED **");
    $finish;
  end

  // full range with the extremes weighted up
  function automatic logic [InW-1:0] any_value();
    int unsigned    pick;
    logic [InW-1:0] v;
    pick = $urandom_range(7);
    if (pick == 0) begin
      v = MaxIn;
    end else if (pick == 1) begin
      v = MinIn;
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  function automatic logic [InW-1:0] near_zero(input int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return v[InW-1:0];
  endfunction

  function automatic logic [InW-1:0] next_temperature();
    logic [InW-1:0] v;
    case ($urandom_range(4))
      0: v = MinIn;
      1: v = MaxIn;
      2: v = '0;
      3: v = $urandom();
      default: v = near_zero(2048);
    endcase
    return v;
  endfunction

  // one point beat; called and left at a falling edge with valid held
  task automatic send_point(input logic [InW-1:0] temp, input logic [InW-1:0] mass);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    final_temperature_i <= temp;
    added_mass_i        <= mass;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    slot = (slot + 1) % NumPoints;
  endtask

  // hold off until every owed fit is out and the block has gone quiet
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (fits_owed != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_temperature(input logic [InW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // random point, shaped per set so fits land in range often
  task automatic send_random_point();
    int unsigned    pick;
    int             xi;
    logic [InW-1:0] temp;
    logic [InW-1:0] mass;
    if (slot == 0) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        shape = SHAPE_FULL;
      end else if (pick < 65) begin
        shape = SHAPE_NARROW;
      end else if (pick < 90) begin
        shape = SHAPE_LINE;
      end else begin
        shape = SHAPE_FLAT_X;
      end
      line_gain = int'($urandom_range(16)) - 8;
      flat_mass = any_value();
    end
    case (shape)
      SHAPE_FULL: begin
        temp = any_value();
        mass = any_value();
      end
      SHAPE_NARROW: begin
        temp = near_zero(4096);
        mass = near_zero(4096);
      end
      SHAPE_LINE: begin
        xi   = int'($urandom_range(4000)) - 2000;
        mass = xi[InW-1:0];
        xi   = xi * line_gain + int'($urandom_range(64)) - 32 + int'(cfg_data_i);
        temp = xi[InW-1:0];
      end
      default: begin
        temp = any_value();
        mass = flat_mass;
      end
    endcase
    send_point(temp, mass);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    final_temperature_i = '0;
    added_mass_i        = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes with the lowest start temperature
    write_temperature(MinIn);
    send_point(MaxIn, MaxIn);
    send_point(MinIn, MinIn);
    send_point('0, MaxIn);
    send_point(MaxIn, MinIn);
    send_point(MinIn, '0);
    send_point(InW'(1), '1);
    drain_and_settle();

    // all x equal gives a zero denominator
    write_temperature(MaxIn);
    for (int k = 0; k < NumPoints; k++) begin
      send_point(InW'(k * 333333), MaxIn);
    end
    drain_and_settle();

    // x spread of one lsb against huge y drives the slope into the clamp
    write_temperature('0);
    for (int k = 0; k < NumPoints - 1; k++) begin
      send_point(MaxIn, '0);
    end
    send_point(MinIn, InW'(1));

    // exact line y = 2x + 768, start temperature changed halfway through the set
    for (int k = 1; k <= NumPoints / 2; k++) begin
      send_point(InW'((2 * k + 3) * 256), InW'(k * 256));
    end
    drain_and_settle();
    write_temperature(InW'(256));
    for (int k = NumPoints / 2 + 1; k <= NumPoints; k++) begin
      send_point(InW'((2 * k + 4) * 256), InW'(k * 256));
    end

    // random sets across three idling phases
    for (int i = 0; i < RandomPoints; i++) begin
      if (i == PhasePoints) begin
        src_idle_pct = 73;
        snk_idle_pct = 29;
      end else if (i == 2 * PhasePoints) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i % TempEvery == 0) begin
        drain_and_settle();
        write_temperature(next_temperature());
      end
      send_random_point();
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("** least_squares_line_fit_top: PASSED **");
    end else begin
      $display("** least_squares_line_fit_top: FAILED **");
    end
    $finish;
  end

endmodule
